FILE: rtl/rwq_pkg.sv
// Shared types, sizes and helpers for the ranked wait queue.
`default_nettype none
package rwq_pkg;

	localparam int NUM_RANKS  = 8;
	localparam int RANK_DEPTH = 16;
	localparam int ID_BITS    = 16;

	localparam int RB = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;
	localparam int LB = $clog2(NUM_RANKS + 1);
	localparam int PB = (RANK_DEPTH > 1) ? $clog2(RANK_DEPTH) : 1;
	localparam int FB = $clog2(RANK_DEPTH + 1);
	localparam int TB = $clog2(NUM_RANKS * RANK_DEPTH + 1);
	localparam int AB = $clog2(NUM_RANKS * RANK_DEPTH);

	localparam logic [1:0] FUNC_PUSH   = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_STATUS = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] waiter_id;
		logic [7:0]  wait_rank;
	} cmd_t;

	typedef struct packed {
		logic [15:0] popped_id;
		logic        popped_valid;
		logic        overflow;
		logic        queue_empty;
		logic [7:0]  waiting_total;
		logic [3:0]  lowest_rank;
	} res_t;

	// update request broadcast to every cell
	typedef struct packed {
		logic          push;
		logic          pop;
		logic [RB-1:0] tgt;
	} cell_cmd_t;

	typedef struct packed {
		logic [PB-1:0] head;
		logic [PB-1:0] tail;
		logic          full;
		logic          nonempty;
	} cell_stat_t;

	// lowest non-empty rank search, passed from cell to cell
	typedef struct packed {
		logic          found;
		logic [LB-1:0] rank;
	} chain_t;

	function automatic logic [PB-1:0] next_pos(input logic [PB-1:0] p);
		return (p == PB'(RANK_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rwq_cell.sv
// One rank of the queue: FIFO pointers, fill count and a link of the lowest-rank search.
`default_nettype none
module rwq_cell
	import rwq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [RB-1:0] my_rank,
	input  wire cell_cmd_t  cmd,
	input  wire chain_t     chain_in,
	output chain_t          chain_out,
	output cell_stat_t      stat
);

	logic [PB-1:0] head_q, tail_q;
	logic [FB-1:0] fill_q;
	logic          sel;
	logic          nonempty;

	assign sel      = (cmd.tgt == my_rank);
	assign nonempty = (fill_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (sel && cmd.push) begin
			tail_q <= next_pos(tail_q);
			fill_q <= fill_q + 1'b1;
		end else if (sel && cmd.pop) begin
			head_q <= next_pos(head_q);
			fill_q <= fill_q - 1'b1;
		end
	end

	assign stat.head     = head_q;
	assign stat.tail     = tail_q;
	assign stat.full     = (fill_q == FB'(RANK_DEPTH));
	assign stat.nonempty = nonempty;

	// first non-empty cell along the chain claims the rank
	assign chain_out.found = chain_in.found | nonempty;
	assign chain_out.rank  = (!chain_in.found && nonempty) ? LB'(my_rank) : chain_in.rank;

endmodule
`default_nettype wire

FILE: rtl/ranked_wait_queue_unit.sv
// Top level of the ranked wait queue: control, entry memory and the row of rank cells.
//
// Usage: commands arrive on cmd (push, pop or status query) under cmd_valid and
// cmd_stall; one result per command leaves on res under res_valid and res_stall.
// A push clamps its rank to the top rank and appends to that rank's FIFO; a full
// FIFO drops it and sets overflow. A pop releases the oldest waiter of the lowest
// non-empty rank. Each result reports emptiness, total and lowest rank afterward.
// Flow: a command passes through the EXEC and DONE states, and its result is
// loaded in DONE once the output is free. A new command is taken in the cycle
// its predecessor's result is loaded, not earlier: EXEC updates the cells and
// accesses the entry memory, whose read data is registered, and DONE builds
// the result from the updated cell row.
// Reset clears all pointers and counts at once; memory contents stay unknown and
// are never read before being written. While res_stall holds a result, the block
// keeps it; the next command executes but waits in DONE until the output is free.
`default_nettype none
module ranked_wait_queue_unit
	import rwq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t        state_q;
	cmd_t          op_q;
	logic [TB-1:0] total_q;
	logic          pv_q, ovf_q;
	logic [ID_BITS-1:0] rd_q;
	logic          res_valid_q;
	res_t          res_q;

	logic [ID_BITS-1:0] mem [NUM_RANKS*RANK_DEPTH];

	cell_cmd_t  ccmd;
	cell_stat_t stat [NUM_RANKS];
	chain_t     chain [NUM_RANKS+1];
	cell_stat_t tstat;
	logic [RB-1:0] push_rank;
	logic [AB-1:0] addr;
	logic       is_push, is_pop, out_free, accept;

	assign chain[0] = '{found: 1'b0, rank: LB'(NUM_RANKS)};

	for (genvar i = 0; i < NUM_RANKS; i++) begin : g_cell
		rwq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.my_rank   (RB'(i)),
			.cmd       (ccmd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.stat      (stat[i])
		);
	end

	assign is_push   = (op_q.func == FUNC_PUSH);
	assign is_pop    = (op_q.func == FUNC_POP);
	assign push_rank = (op_q.wait_rank > 8'(NUM_RANKS - 1)) ? RB'(NUM_RANKS - 1)
	                                                         : RB'(op_q.wait_rank);

	always_comb begin
		ccmd.tgt  = is_push ? push_rank : RB'(chain[NUM_RANKS].rank);
		tstat     = stat[ccmd.tgt];
		ccmd.push = (state_q == ST_EXEC) && is_push && !tstat.full;
		ccmd.pop  = (state_q == ST_EXEC) && is_pop && chain[NUM_RANKS].found;
	end

	assign addr = AB'(ccmd.tgt) * AB'(RANK_DEPTH) + AB'(ccmd.push ? tstat.tail : tstat.head);

	always_ff @(posedge clk) begin
		if (ccmd.push)
			mem[addr] <= ID_BITS'(op_q.waiter_id);
		if (ccmd.pop)
			rd_q <= mem[addr];
	end

	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = !((state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free));
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (ccmd.push)
						total_q <= total_q + 1'b1;
					else if (ccmd.pop)
						total_q <= total_q - 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= accept ? ST_EXEC : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (res_valid_q && !res_stall && !(state_q == ST_DONE))
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			op_q <= cmd;
		if (state_q == ST_EXEC) begin
			pv_q  <= ccmd.pop;
			ovf_q <= is_push && tstat.full;
		end
		if (state_q == ST_DONE && out_free) begin
			res_q.popped_id     <= pv_q ? 16'(rd_q) : 16'd0;
			res_q.popped_valid  <= pv_q;
			res_q.overflow      <= ovf_q;
			res_q.queue_empty   <= (total_q == '0);
			res_q.waiting_total <= 8'(total_q);
			res_q.lowest_rank   <= 4'(chain[NUM_RANKS].rank);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> state_q == ST_EXEC)
		else $error("accepted command did not start execution");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_total_chain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> ((total_q == '0) == !chain[NUM_RANKS].found))
		else $error("total count disagrees with rank cells");

	a_pop_not_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.popped_valid && res.overflow))
		else $error("result flags both pop and overflow");

endmodule
`default_nettype wire
